// ===== rtl/ewmads_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ewmads_pkg;

	// Default widths of the measured duration and of the weight fraction
	localparam int DURATION_BITS_DEF    = 24;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;

	// Fixed field formats
	localparam int MEAN_FRAC = 16;
	localparam int VAR_W     = 64;
	localparam int DEV_W     = 32;

	// Shared multiplier: one digit of the multiplier per cycle, exact 128-bit product
	localparam int ACC_W   = 128;
	localparam int DIGIT_W = 8;
	localparam int CNT_W   = 4;

	// Integer square root: one root bit per cycle
	localparam int ROOT_STEPS = 32;
	localparam int ROOT_CNT_W = 6;
	localparam int REM_W      = 35;

	// Register file
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT = 1'b0;

	typedef struct packed {
		logic             start;
		logic             keep;
		logic [CNT_W-1:0] digits;
	} mul_ctl_t;

	typedef struct packed {
		logic busy;
	} mul_sts_t;

endpackage

`default_nettype wire

// ===== rtl/ewmads_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ewmads_mul #(
	parameter int MC_W = 57,
	parameter int MP_W = 65
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  ewmads_pkg::mul_ctl_t       ctl,
	input  wire  [MC_W-1:0]                  mcand,
	input  wire  [MP_W-1:0]                  mplier,
	output ewmads_pkg::mul_sts_t             sts,
	output logic [ewmads_pkg::ACC_W-1:0]     acc
);
	import ewmads_pkg::*;

	logic [CNT_W-1:0]         cnt_q;
	logic [ACC_W-1:0]         mc_q;
	logic [MP_W-1:0]          mp_q;
	logic [ACC_W-1:0]         acc_q;
	logic [ACC_W+DIGIT_W-1:0] pp;

	// partial product of the current multiplier digit
	assign pp = mc_q * mp_q[DIGIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= ctl.digits;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mc_q  <= ACC_W'(mcand);
			mp_q  <= mplier;
			acc_q <= ctl.keep ? acc_q : '0;
		end else if (cnt_q != '0) begin
			acc_q <= acc_q + pp[ACC_W-1:0];
			mc_q  <= mc_q << DIGIT_W;
			mp_q  <= mp_q >> DIGIT_W;
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign acc      = acc_q;

endmodule

`default_nettype wire

// ===== rtl/ewmads_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ewmads_sqrt (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire  [ewmads_pkg::VAR_W-1:0]      radicand,
	output logic                              busy,
	output logic [ewmads_pkg::DEV_W-1:0]      root
);
	import ewmads_pkg::*;

	logic [ROOT_CNT_W-1:0] cnt_q;
	logic [VAR_W-1:0]      rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [DEV_W-1:0]      root_q;
	logic [REM_W-1:0]      rem_n;
	logic [REM_W-1:0]      trial;
	logic                  fits;

	// bring down the next two radicand bits, try root*4+1
	assign rem_n = {rem_q[REM_W-3:0], rad_q[VAR_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = (rem_n >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= ROOT_CNT_W'(ROOT_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? rem_n - trial : rem_n;
			root_q <= {root_q[DEV_W-2:0], fits};
		end
	end

	assign busy = (cnt_q != '0);
	assign root = root_q;

endmodule

`default_nettype wire

// ===== rtl/ewma_duration_statistics_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_*       in   s_tvalid / s_tready          s_tdata: duration
// m_*       out  m_tvalid / m_tready          m_tdata: last, mean, variance, deviation,
//                                                      min, max
// APB       in   psel, penable, pwrite        paddr, pwdata, prdata (smoothing_weight)
//
// One item passes through the digit-serial multiplier (8 multiplier bits a cycle, five products
// in a row) and the 32-step square root. s_tready is high only while the sequencer is idle.
// A finished item waits in the output register; the next item is accepted meanwhile.
// Reset clears the statistics (minimum to all ones) and loads alpha = 0.1.

module ewma_duration_statistics_unit #(
	parameter int DURATION_BITS    = ewmads_pkg::DURATION_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = ewmads_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// duration
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [((DURATION_BITS+7)/8)*8-1:0] s_tdata,
	// last, mean, variance, deviation, min, max (lowest bits first)
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [((4*DURATION_BITS+ewmads_pkg::MEAN_FRAC+ewmads_pkg::VAR_W
		+ewmads_pkg::DEV_W+7)/8)*8-1:0]         m_tdata,
	// configuration
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [ewmads_pkg::PADDR_W-1:0]     paddr,
	input  wire  [ewmads_pkg::PDATA_W-1:0]     pwdata,
	output logic [ewmads_pkg::PDATA_W-1:0]     prdata,
	output logic                               pready
);
	import ewmads_pkg::*;

	localparam int D      = DURATION_BITS;
	localparam int W      = WEIGHT_FRAC_BITS;
	localparam int WT_W   = W + 1;
	localparam int MEAN_W = D + MEAN_FRAC;
	localparam int TERM_W = 2 * D + MEAN_FRAC;
	localparam int S_W    = ((TERM_W > VAR_W) ? TERM_W : VAR_W) + 1;
	localparam int MC_W   = MEAN_W + WT_W;
	localparam int MP_W   = S_W;
	localparam int DIG_A  = (WT_W + DIGIT_W - 1) / DIGIT_W;
	localparam int DIG_D  = (MEAN_W + DIGIT_W - 1) / DIGIT_W;
	localparam int DIG_S  = (S_W + DIGIT_W - 1) / DIGIT_W;
	localparam int FLD_W  = 4 * D + MEAN_FRAC + VAR_W + DEV_W;
	localparam int OUT_W  = ((FLD_W + 7) / 8) * 8;
	localparam logic [WT_W-1:0] ONE        = WT_W'(1) << W;
	localparam logic [WT_W-1:0] WEIGHT_RST = WT_W'(((2 ** W) + 5) / 10);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN_AX,
		ST_WAIT_AX,
		ST_MEAN_BM,
		ST_WAIT_BM,
		ST_VAR_AD,
		ST_WAIT_AD,
		ST_VAR_DD,
		ST_WAIT_DD,
		ST_VAR_SUM,
		ST_VAR_SB,
		ST_WAIT_SB,
		ST_ROOT,
		ST_WAIT_ROOT,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [WT_W-1:0]   weight_q;
	logic [WT_W-1:0]   a_q;
	logic [WT_W-1:0]   b_q;
	logic [MEAN_W-1:0] diff_q;
	logic [MEAN_W-1:0] mean_q;
	logic [VAR_W-1:0]  var_q;
	logic [S_W-1:0]    s_q;
	logic [D-1:0]      last_q;
	logic [D-1:0]      min_q;
	logic [D-1:0]      max_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic              cfg_wr;
	logic [WT_W-1:0]   a_in;
	logic [D-1:0]      d_in;
	logic [MEAN_W-1:0] x_in;
	logic              in_acc;
	logic              out_free;

	mul_ctl_t          mul_ctl;
	mul_sts_t          mul_sts;
	logic [MC_W-1:0]   mul_mcand;
	logic [MP_W-1:0]   mul_mplier;
	logic [ACC_W-1:0]  mul_acc;
	logic              sq_start;
	logic              sq_busy;
	logic [DEV_W-1:0]  sq_root;

	// ---------------------------------------------------------------- configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_WEIGHT);
	assign prdata = (paddr[PADDR_W-1:2] == REG_WEIGHT) ? PDATA_W'(weight_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RST;
		end else if (cfg_wr) begin
			weight_q <= pwdata[WT_W-1:0];
		end
	end

	// ---------------------------------------------------------------- input side
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign d_in     = s_tdata[D-1:0];
	assign x_in     = {d_in, {MEAN_FRAC{1'b0}}};
	// clamp a weight above one to exactly one
	assign a_in     = (weight_q > ONE) ? ONE : weight_q;
	assign out_free = !m_tvalid_q || m_tready;

	// ---------------------------------------------------------------- shared multiplier
	// Products, in order:
	//   a*X + (1-a)*mean      -> new mean (second product accumulates onto the first)
	//   a*|X-mean|            -> kept in the multiplier's accumulator
	//   (a*|X-mean|)*|X-mean| -> variance term after dropping 16+W fraction bits
	//   (var+term)*(1-a)      -> new variance after dropping W bits, saturated
	always_comb begin
		mul_ctl.start  = 1'b0;
		mul_ctl.keep   = 1'b0;
		mul_ctl.digits = CNT_W'(DIG_A);
		mul_mcand      = '0;
		mul_mplier     = '0;
		case (state_q)
			ST_MEAN_AX: begin
				mul_ctl.start = 1'b1;
				mul_mcand     = MC_W'({last_q, {MEAN_FRAC{1'b0}}});
				mul_mplier    = MP_W'(a_q);
			end
			ST_MEAN_BM: begin
				mul_ctl.start = 1'b1;
				mul_ctl.keep  = 1'b1;
				mul_mcand     = MC_W'(mean_q);
				mul_mplier    = MP_W'(b_q);
			end
			ST_VAR_AD: begin
				mul_ctl.start = 1'b1;
				mul_mcand     = MC_W'(diff_q);
				mul_mplier    = MP_W'(a_q);
			end
			ST_VAR_DD: begin
				mul_ctl.start  = 1'b1;
				mul_ctl.digits = CNT_W'(DIG_D);
				mul_mcand      = mul_acc[MC_W-1:0];
				mul_mplier     = MP_W'(diff_q);
			end
			ST_VAR_SB: begin
				mul_ctl.start  = 1'b1;
				mul_ctl.digits = CNT_W'(DIG_S);
				mul_mcand      = MC_W'(b_q);
				mul_mplier     = s_q;
			end
			default: begin
			end
		endcase
	end

	ewmads_mul #(
		.MC_W (MC_W),
		.MP_W (MP_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.mcand  (mul_mcand),
		.mplier (mul_mplier),
		.sts    (mul_sts),
		.acc    (mul_acc)
	);

	assign sq_start = (state_q == ST_ROOT);

	ewmads_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (var_q),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			a_q        <= '0;
			b_q        <= '0;
			diff_q     <= '0;
			mean_q     <= '0;
			var_q      <= '0;
			s_q        <= '0;
			last_q     <= '0;
			min_q      <= '1;
			max_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// show a finished item, drop the shown item once taken
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						a_q    <= a_in;
						b_q    <= ONE - a_in;
						diff_q <= (x_in >= mean_q) ? x_in - mean_q : mean_q - x_in;
						last_q <= d_in;
						if (d_in < min_q) begin
							min_q <= d_in;
						end
						if (d_in > max_q) begin
							max_q <= d_in;
						end
						state_q <= ST_MEAN_AX;
					end
				end
				ST_MEAN_AX: state_q <= ST_WAIT_AX;
				ST_WAIT_AX: begin
					if (!mul_sts.busy) begin
						state_q <= ST_MEAN_BM;
					end
				end
				ST_MEAN_BM: state_q <= ST_WAIT_BM;
				ST_WAIT_BM: begin
					if (!mul_sts.busy) begin
						mean_q  <= mul_acc[W +: MEAN_W];
						state_q <= ST_VAR_AD;
					end
				end
				ST_VAR_AD: state_q <= ST_WAIT_AD;
				ST_WAIT_AD: begin
					if (!mul_sts.busy) begin
						state_q <= ST_VAR_DD;
					end
				end
				ST_VAR_DD: state_q <= ST_WAIT_DD;
				ST_WAIT_DD: begin
					if (!mul_sts.busy) begin
						state_q <= ST_VAR_SUM;
					end
				end
				ST_VAR_SUM: begin
					s_q     <= S_W'(var_q) + S_W'(mul_acc[MEAN_FRAC + W +: TERM_W]);
					state_q <= ST_VAR_SB;
				end
				ST_VAR_SB: state_q <= ST_WAIT_SB;
				ST_WAIT_SB: begin
					if (!mul_sts.busy) begin
						// saturate when anything lands above the 64-bit result
						var_q   <= (|mul_acc[ACC_W-1:W+VAR_W]) ? '1 : mul_acc[W +: VAR_W];
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: state_q <= ST_WAIT_ROOT;
				ST_WAIT_ROOT: begin
					if (!sq_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						m_tdata_q  <= OUT_W'({max_q, min_q, sq_root, var_q, mean_q, last_q});
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
